@@ rtl/hpm_pkg.sv @@
`timescale 1ns / 1ps

package hpm_pkg;

    localparam int KeyWidth = 8;
    localparam int ModWidth = 4;
    localparam int CfgDataWidth = 8;
    localparam int CfgIndexWidth = 2;

    // register indexes on the configuration port
    localparam logic [CfgIndexWidth-1:0] CFG_BINDING_KEY       = 2'd0;
    localparam logic [CfgIndexWidth-1:0] CFG_BINDING_MODIFIERS = 2'd1;
    localparam logic [CfgIndexWidth-1:0] CFG_STARTUP_MODIFIERS = 2'd2;

    localparam logic [KeyWidth-1:0] VK_BACKSPACE = 8'h08;
    localparam logic [KeyWidth-1:0] VK_TAB       = 8'h09;
    localparam logic [KeyWidth-1:0] VK_ESCAPE    = 8'h1B;
    localparam logic [KeyWidth-1:0] VK_DELETE    = 8'h2E;
    localparam logic [KeyWidth-1:0] VK_RIGHT_ALT = 8'hA5;
    localparam logic [KeyWidth-1:0] VK_LAST      = 8'hFE;

    localparam logic [ModWidth-1:0] MOD_CONTROL = 4'h2;
    localparam logic [ModWidth-1:0] MOD_ALT     = 4'h4;
    localparam logic [ModWidth-1:0] MOD_WINDOWS = 4'h8;

    typedef struct packed {
        logic [KeyWidth-1:0] key_code;
        logic [ModWidth-1:0] event_modifier_bits;
        logic                right_alt_flag;
        logic                key_down;
        logic                injected_flag;
        logic                track_external;
    } key_item_t;

    typedef struct packed {
        logic consume;
        logic toggle;
        logic foreign_press;
        logic binding_valid;
    } result_t;

    typedef struct packed {
        logic capture;
        logic clear_step;
        logic note_step;
        logic scan_start;
        logic scan_step;
        logic decide;
        logic publish;
    } hpm_cmd_t;

    typedef struct packed {
        logic need_scan;
        logic addr_last;
        logic out_free;
    } hpm_status_t;

    function automatic logic is_modifier_vk(input logic [KeyWidth-1:0] k);
        return k inside {8'h10, 8'h11, 8'h12, [8'hA0:8'hA5], 8'h5B, 8'h5C};
    endfunction

    function automatic logic is_typing_vk(input logic [KeyWidth-1:0] k);
        return k inside {[8'h30:8'h39], [8'h41:8'h5A], [8'h60:8'h6F], [8'hBA:8'hE2],
                         8'h20, 8'h0D, VK_BACKSPACE};
    endfunction

    function automatic logic binding_allowed(input logic [KeyWidth-1:0] k,
                                             input logic [ModWidth-1:0] m);
        logic [ModWidth-1:0] ca;
        logic                ok;
        ca = MOD_CONTROL | MOD_ALT;
        if (k < VK_BACKSPACE || k > VK_LAST || (m & MOD_WINDOWS) != '0)
            ok = 1'b0;
        else if (k == VK_RIGHT_ALT)
            ok = (m == '0);
        else if (is_modifier_vk(k) || k == VK_ESCAPE || k == VK_TAB)
            ok = 1'b0;
        else if (k == VK_DELETE && (m & ca) == ca)
            ok = 1'b0;
        else
            ok = !is_typing_vk(k) || (m & ca) != '0;
        return ok;
    endfunction

endpackage

@@ rtl/hpm_if.sv @@
`timescale 1ns / 1ps

interface hpm_key_if;
    logic       valid;
    logic       ready;
    logic [7:0] key_code;
    logic [3:0] event_modifier_bits;
    logic       right_alt_flag;
    logic       key_down;
    logic       injected_flag;
    logic       track_external;

    modport source (
        output valid, key_code, event_modifier_bits, right_alt_flag, key_down,
               injected_flag, track_external,
        input  ready
    );
    modport sink (
        input  valid, key_code, event_modifier_bits, right_alt_flag, key_down,
               injected_flag, track_external,
        output ready
    );
endinterface

interface hpm_result_if;
    logic valid;
    logic ready;
    logic consume;
    logic toggle;
    logic foreign_press;
    logic binding_valid;

    modport source (
        output valid, consume, toggle, foreign_press, binding_valid,
        input  ready
    );
    modport sink (
        input  valid, consume, toggle, foreign_press, binding_valid,
        output ready
    );
endinterface

@@ rtl/hpm_ram.sv @@
`timescale 1ns / 1ps

module hpm_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ rtl/hpm_ctrl.sv @@
`timescale 1ns / 1ps

module hpm_ctrl
    import hpm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  hpm_status_t status,
    output hpm_cmd_t    cmd
);

    typedef enum logic [6:0] {
        ST_CLEAR    = 7'b0000001,
        ST_IDLE     = 7'b0000010,
        ST_NOTE     = 7'b0000100,
        ST_SCAN     = 7'b0001000,
        ST_SCAN_END = 7'b0010000,
        ST_DECIDE   = 7'b0100000,
        ST_DONE     = 7'b1000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear_step = 1'b1;
                if (status.addr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.capture = in_valid;
                if (in_valid)
                begin
                    state_next = ST_NOTE;
                end
            end
            ST_NOTE:
            begin
                cmd.note_step  = 1'b1;
                cmd.scan_start = 1'b1;
                state_next     = status.need_scan ? ST_SCAN : ST_DECIDE;
            end
            ST_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (status.addr_last)
                begin
                    state_next = ST_SCAN_END;
                end
            end
            ST_SCAN_END:
            begin
                state_next = ST_DECIDE;
            end
            ST_DECIDE:
            begin
                cmd.decide = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (status.out_free)
                begin
                    cmd.publish = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

endmodule

@@ rtl/hpm_datapath.sv @@
`timescale 1ns / 1ps

module hpm_datapath
    import hpm_pkg::*;
#(
    parameter int KEY_TABLE_DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  hpm_cmd_t                 cmd,
    output hpm_status_t              status,
    input  logic                     cfg_write,
    input  logic [CfgIndexWidth-1:0] cfg_index,
    input  logic [CfgDataWidth-1:0]  cfg_data,
    input  key_item_t                in_item,
    output logic                     out_valid,
    input  logic                     out_ready,
    output result_t                  out_result
);

    localparam int AW = $clog2(KEY_TABLE_DEPTH);
    localparam logic [AW-1:0] LastAddr = AW'(KEY_TABLE_DEPTH - 1);

    logic [KeyWidth-1:0] binding_key_reg;
    logic [ModWidth-1:0] binding_mods_reg;
    logic [ModWidth-1:0] seeded_reg;
    logic [ModWidth-1:0] seeded_next;
    logic                held_reg;
    logic                held_next;
    logic [AW-1:0]       addr_reg;
    logic [AW-1:0]       addr_next;
    logic                rd_pending_reg;
    logic                out_valid_reg;
    logic                out_valid_next;

    key_item_t           item_reg;
    logic [ModWidth-1:0] acc_reg;
    result_t             res_reg;
    result_t             res_next;
    result_t             out_reg;

    logic                key_hit;
    logic                in_range;
    logic                mod_event;
    logic                note_down;
    logic                note_up;
    logic                combo_match;
    logic                cfg_mod;
    logic [ModWidth-1:0] held_mods;

    logic                ram_we;
    logic [AW-1:0]       ram_waddr;
    logic [ModWidth-1:0] ram_wdata;
    logic [ModWidth-1:0] ram_rdata;

    assign key_hit     = (binding_key_reg == VK_RIGHT_ALT) ? item_reg.right_alt_flag
                                                           : (item_reg.key_code == binding_key_reg);
    assign in_range    = {1'b0, item_reg.key_code} < (KeyWidth + 1)'(KEY_TABLE_DEPTH);
    assign mod_event   = !item_reg.injected_flag && (item_reg.event_modifier_bits != '0);
    assign note_down   = cmd.note_step && mod_event && item_reg.key_down;
    assign note_up     = cmd.decide && mod_event && !item_reg.key_down;
    assign held_mods   = seeded_reg | acc_reg;
    assign combo_match = key_hit && (binding_key_reg == VK_RIGHT_ALT ||
                                     held_mods == binding_mods_reg);
    assign cfg_mod     = (item_reg.event_modifier_bits & binding_mods_reg) != '0;

    assign status.need_scan = !item_reg.injected_flag && key_hit &&
                              binding_key_reg != VK_RIGHT_ALT;
    assign status.addr_last = (addr_reg == LastAddr);
    assign status.out_free  = !out_valid_reg || out_ready;

    // one write port shared by the clearing pass and the modifier updates
    assign ram_we    = cmd.clear_step || ((note_down || note_up) && in_range);
    assign ram_waddr = cmd.clear_step ? addr_reg : item_reg.key_code[AW-1:0];
    assign ram_wdata = note_down ? item_reg.event_modifier_bits : '0;

    hpm_ram #(
        .WIDTH (ModWidth),
        .DEPTH (KEY_TABLE_DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (addr_reg),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        res_next               = '0;
        res_next.binding_valid = binding_allowed(binding_key_reg, binding_mods_reg);
        held_next              = held_reg;
        if (cmd.decide && !item_reg.injected_flag)
        begin
            if (key_hit && held_reg)
            begin
                res_next.consume = 1'b1;
                if (!item_reg.key_down)
                begin
                    held_next = 1'b0;
                end
            end
            else if (combo_match && item_reg.key_down)
            begin
                held_next        = 1'b1;
                res_next.consume = 1'b1;
                res_next.toggle  = 1'b1;
            end
            else if (item_reg.key_down && !cfg_mod && item_reg.track_external)
            begin
                res_next.foreign_press = 1'b1;
            end
        end
        if (cfg_write && (cfg_index == CFG_BINDING_KEY || cfg_index == CFG_BINDING_MODIFIERS))
        begin
            held_next = 1'b0;
        end
    end

    always_comb
    begin
        seeded_next = seeded_reg;
        if (cfg_write && cfg_index == CFG_STARTUP_MODIFIERS)
        begin
            seeded_next = cfg_data[ModWidth-1:0];
        end
        else if (note_down || note_up)
        begin
            seeded_next = seeded_reg & ~item_reg.event_modifier_bits;
        end
    end

    always_comb
    begin
        addr_next = addr_reg;
        if (cmd.scan_start)
        begin
            addr_next = '0;
        end
        else if (cmd.clear_step || cmd.scan_step)
        begin
            addr_next = status.addr_last ? '0 : addr_reg + 1'b1;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.publish)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            binding_key_reg  <= '0;
            binding_mods_reg <= '0;
            seeded_reg       <= '0;
            held_reg         <= 1'b0;
            addr_reg         <= '0;
            rd_pending_reg   <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_write && cfg_index == CFG_BINDING_KEY)
            begin
                binding_key_reg <= cfg_data[KeyWidth-1:0];
            end
            if (cfg_write && cfg_index == CFG_BINDING_MODIFIERS)
            begin
                binding_mods_reg <= cfg_data[ModWidth-1:0];
            end
            seeded_reg     <= seeded_next;
            held_reg       <= held_next;
            addr_reg       <= addr_next;
            rd_pending_reg <= cmd.scan_step;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            item_reg <= in_item;
        end
        // read data arrives in the cycle after its address
        if (cmd.scan_start)
        begin
            acc_reg <= '0;
        end
        else if (rd_pending_reg)
        begin
            acc_reg <= acc_reg | ram_rdata;
        end
        if (cmd.decide)
        begin
            res_reg <= res_next;
        end
        if (cmd.publish)
        begin
            out_reg <= res_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_result = out_reg;

endmodule

@@ rtl/hotkey_press_matcher_core.sv @@
`timescale 1ns / 1ps
// a word is captured and noted; when a non-injected event hits the bound key (and that key is
// not right alt) the modifier table is walked one entry a cycle through the ram read port
// one word at a time: next word taken the cycle after the previous one reaches the output
// register, where the result waits while the result port stalls
// reset: asynchronous active low; then a clearing pass zeroes the table, during which no
// word is taken (configuration writes still land)

module hotkey_press_matcher_core
    import hpm_pkg::*;
#(
    parameter int KEY_TABLE_DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_write,
    input  logic [CfgIndexWidth-1:0] cfg_index,
    input  logic [CfgDataWidth-1:0]  cfg_data,
    hpm_key_if.sink                  keys,
    hpm_result_if.source             results
);

    hpm_cmd_t    cmd;
    hpm_status_t status;
    key_item_t   in_item;
    result_t     out_result;
    logic        in_ready;
    logic        out_valid;

    assign in_item.key_code            = keys.key_code;
    assign in_item.event_modifier_bits = keys.event_modifier_bits;
    assign in_item.right_alt_flag      = keys.right_alt_flag;
    assign in_item.key_down            = keys.key_down;
    assign in_item.injected_flag       = keys.injected_flag;
    assign in_item.track_external      = keys.track_external;
    assign keys.ready                  = in_ready;

    assign results.valid         = out_valid;
    assign results.consume       = out_result.consume;
    assign results.toggle        = out_result.toggle;
    assign results.foreign_press = out_result.foreign_press;
    assign results.binding_valid = out_result.binding_valid;

    hpm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (keys.valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    hpm_datapath #(
        .KEY_TABLE_DEPTH (KEY_TABLE_DEPTH)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .status     (status),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_item    (in_item),
        .out_valid  (out_valid),
        .out_ready  (results.ready),
        .out_result (out_result)
    );

endmodule

@@ rtl/hpm_checker.sv @@
`timescale 1ns / 1ps

module hpm_checker (
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready,
    input logic consume,
    input logic toggle,
    input logic foreign_press
);

    // one word in flight: no second accept right after one
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("word accepted on back-to-back cycles");

    a_toggle_consumes: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && toggle |-> consume)
        else $error("toggle without consume");

    a_external_not_consumed: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && foreign_press |-> !consume && !toggle)
        else $error("foreign press flagged on a consumed word");

    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

endmodule

bind hotkey_press_matcher_core hpm_checker u_hpm_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (keys.valid),
    .in_ready      (keys.ready),
    .out_valid     (results.valid),
    .out_ready     (results.ready),
    .consume       (results.consume),
    .toggle        (results.toggle),
    .foreign_press (results.foreign_press)
);

@@ tb/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
    import hpm_pkg::*;

    localparam int TABLE_DEPTH    = 256;
    localparam int SETTLE_CYCLES  = TABLE_DEPTH + 8;
    localparam int LONG_HOLD      = 1500;
    localparam int WATCHDOG_LIMIT = 6000;
    localparam int PHASES         = 10;
    localparam int PHASE_EVENTS   = 165;

    logic                     clk;
    logic                     rst_n;
    logic                     cfg_write;
    logic [CfgIndexWidth-1:0] cfg_index;
    logic [CfgDataWidth-1:0]  cfg_data;

    hpm_key_if    key_ch ();
    hpm_result_if verdict_ch ();

    hotkey_press_matcher_core #(
        .KEY_TABLE_DEPTH (TABLE_DEPTH)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .keys      (key_ch.sink),
        .results   (verdict_ch.source)
    );

    // per-phase binding: hotkey, required modifiers, startup snapshot
    logic [7:0] phase_key  [PHASES] = '{8'h41, 8'hA5, 8'hFF, 8'h00, 8'h70,
                                        8'h2E, 8'h20, 8'h1B, 8'h09, 8'hA5};
    logic [3:0] phase_mods [PHASES] = '{4'd2, 4'd0, 4'd15, 4'd0, 4'd0,
                                        4'd6, 4'd4, 4'd3, 4'd2, 4'd1};
    logic [3:0] phase_boot [PHASES] = '{4'd0, 4'd15, 4'd0, 4'd5, 4'd2,
                                        4'd0, 4'd1, 4'd15, 4'd8, 4'd4};

    string verdict_fields [4] = '{"consume", "toggle", "foreign_press", "binding_valid"};

    // shadow of the matcher state
    logic [3:0] mod_table [TABLE_DEPTH];
    logic [3:0] seeded_mods;
    logic       hotkey_held;
    logic [7:0] bound_key;
    logic [3:0] bound_mods;

    key_item_t key_backlog [$];
    result_t   due_verdicts [$];
    int        queued_events;
    int        settled_events;
    int        mismatches;
    int        send_idle_pct;
    int        stall_pct;
    int        hold_requests;
    int        holds_served;
    int        hold_left;
    int        quiet_cycles;
    logic      key_fire;

    always #6 clk = ~clk;

    function automatic logic [3:0] key_modifier_bit(input logic [7:0] k);
        case (k)
            8'h10, 8'hA0, 8'hA1: return 4'h1;
            8'h11, 8'hA2, 8'hA3: return MOD_CONTROL;
            8'h12, 8'hA4, 8'hA5: return MOD_ALT;
            8'h5B, 8'h5C:        return MOD_WINDOWS;
            default:             return 4'h0;
        endcase
    endfunction

    function automatic logic pick_typing(input logic [7:0] k);
        return (k >= 8'h30 && k <= 8'h39) || (k >= 8'h41 && k <= 8'h5A) ||
               (k >= 8'h60 && k <= 8'h6F) || (k >= 8'hBA && k <= 8'hE2) ||
               k == 8'h20 || k == 8'h0D || k == VK_BACKSPACE;
    endfunction

    function automatic logic binding_ok(input logic [7:0] k, input logic [3:0] m);
        logic [3:0] ctl_alt;
        ctl_alt = MOD_CONTROL | MOD_ALT;
        if (k < VK_BACKSPACE || k > VK_LAST || (m & MOD_WINDOWS) != 4'h0)
            return 1'b0;
        if (k == VK_RIGHT_ALT)
            return m == 4'h0;
        if (key_modifier_bit(k) != 4'h0 || k == VK_ESCAPE || k == VK_TAB)
            return 1'b0;
        if (k == VK_DELETE && (m & ctl_alt) == ctl_alt)
            return 1'b0;
        return !pick_typing(k) || (m & ctl_alt) != 4'h0;
    endfunction

    function automatic void record_modifier(input logic [7:0] k, input logic [3:0] m,
                                            input logic down);
        if (m != 4'h0)
        begin
            seeded_mods = seeded_mods & ~m;
            mod_table[k] = down ? m : 4'h0;
        end
    endfunction

    function automatic result_t judge_key_event(input key_item_t ev);
        result_t    r;
        logic [3:0] held_mask;
        logic       key_hit;
        logic       hit;
        logic       cfg_mod;
        r = '0;
        if (!ev.injected_flag)
        begin
            if (ev.key_down)
                record_modifier(ev.key_code, ev.event_modifier_bits, 1'b1);
            key_hit = (bound_key == VK_RIGHT_ALT) ? ev.right_alt_flag
                                                 : (ev.key_code == bound_key);
            held_mask = seeded_mods;
            for (int i = 0; i < TABLE_DEPTH; i++)
                held_mask = held_mask | mod_table[i];
            hit = key_hit && (bound_key == VK_RIGHT_ALT || held_mask == bound_mods);
            cfg_mod = (ev.event_modifier_bits & bound_mods) != 4'h0;
            if (key_hit && hotkey_held)
            begin
                r.consume = 1'b1;
                if (!ev.key_down)
                    hotkey_held = 1'b0;
            end
            else if (hit && ev.key_down)
            begin
                hotkey_held = 1'b1;
                r.consume = 1'b1;
                r.toggle = 1'b1;
            end
            else if (ev.key_down && !cfg_mod && ev.track_external)
                r.foreign_press = 1'b1;
            if (!ev.key_down)
                record_modifier(ev.key_code, ev.event_modifier_bits, 1'b0);
        end
        r.binding_valid = binding_ok(bound_key, bound_mods);
        return r;
    endfunction

    function automatic logic [7:0] pick_modifier_key(input int b);
        case (b)
            0:       return ($urandom_range(2) == 0) ? 8'h10 : 8'($urandom_range(8'hA0, 8'hA1));
            1:       return ($urandom_range(2) == 0) ? 8'h11 : 8'($urandom_range(8'hA2, 8'hA3));
            2:       return ($urandom_range(2) == 0) ? 8'h12 : 8'($urandom_range(8'hA4, 8'hA5));
            default: return $urandom_range(1) ? 8'h5B : 8'h5C;
        endcase
    endfunction

    task automatic add_key(input logic [7:0] k, input logic [3:0] emod, input logic ralt,
                           input logic down, input logic inj, input logic trk);
        key_item_t ev;
        ev.key_code = k;
        ev.event_modifier_bits = emod;
        ev.right_alt_flag = ralt;
        ev.key_down = down;
        ev.injected_flag = inj;
        ev.track_external = trk;
        key_backlog.push_back(ev);
        queued_events++;
    endtask

    // modifiers down, a key (usually the hotkey) pressed once or repeated, then most keys let go
    task automatic add_chord();
        logic [3:0] want;
        logic [7:0] down_keys [$];
        logic [7:0] k;
        logic [7:0] target;
        logic       trk;
        int         b;
        want = $urandom_range(1) ? bound_mods : 4'($urandom_range(15));
        trk = 1'($urandom_range(1));
        for (b = 0; b < 4; b++)
        begin
            if (want[b])
            begin
                k = pick_modifier_key(b);
                down_keys.push_back(k);
                add_key(k, 4'(1 << b), k == VK_RIGHT_ALT, 1'b1, $urandom_range(24) == 0, trk);
            end
        end
        target = ($urandom_range(9) < 7) ? bound_key : 8'($urandom);
        repeat ($urandom_range(1, 3))
            add_key(target, key_modifier_bit(target), target == VK_RIGHT_ALT, 1'b1,
                    $urandom_range(24) == 0, trk);
        if ($urandom_range(4) != 0)
            add_key(target, key_modifier_bit(target), target == VK_RIGHT_ALT, 1'b0,
                    $urandom_range(24) == 0, trk);
        while (down_keys.size() != 0)
        begin
            k = down_keys.pop_back();
            if ($urandom_range(6) != 0)
                add_key(k, key_modifier_bit(k), k == VK_RIGHT_ALT, 1'b0,
                        $urandom_range(24) == 0, trk);
        end
    endtask

    task automatic add_noise();
        add_key(8'($urandom),
                ($urandom_range(9) == 0) ? 4'($urandom_range(1, 15)) : 4'h0,
                1'($urandom_range(1)), 1'($urandom_range(1)),
                $urandom_range(3) == 0, 1'($urandom_range(1)));
    endtask

    // the whole binding is written on consecutive edges with the strobe held high
    task automatic program_binding(input logic [7:0] k, input logic [3:0] m,
                                   input logic [3:0] boot);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= CFG_BINDING_KEY;
        cfg_data  <= k;
        bound_key = k;
        hotkey_held = 1'b0;
        @(negedge clk);
        cfg_index <= CFG_BINDING_MODIFIERS;
        cfg_data  <= {4'($urandom_range(15)), m};
        bound_mods = m;
        @(negedge clk);
        cfg_index <= CFG_STARTUP_MODIFIERS;
        cfg_data  <= {4'($urandom_range(15)), boot};
        seeded_mods = boot;
        @(negedge clk);
        cfg_write <= 1'b0;
    endtask

    task automatic wait_settled();
        while (settled_events != queued_events)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // word driver
    always @(negedge clk)
    begin
        key_item_t nxt;
        if (!key_ch.valid || key_fire)
        begin
            if (key_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                nxt = key_backlog.pop_front();
                key_ch.valid               <= 1'b1;
                key_ch.key_code            <= nxt.key_code;
                key_ch.event_modifier_bits <= nxt.event_modifier_bits;
                key_ch.right_alt_flag      <= nxt.right_alt_flag;
                key_ch.key_down            <= nxt.key_down;
                key_ch.injected_flag       <= nxt.injected_flag;
                key_ch.track_external      <= nxt.track_external;
            end
            else
                key_ch.valid <= 1'b0;
        end
    end

    // result receiver, with a single long hold-off
    always @(negedge clk)
    begin
        if (hold_requests != holds_served)
        begin
            hold_left = LONG_HOLD;
            holds_served = hold_requests;
        end
        if (hold_left > 0)
        begin
            verdict_ch.ready <= 1'b0;
            hold_left--;
        end
        else
            verdict_ch.ready <= ($urandom_range(99) >= stall_pct);
    end

    // monitor
    always @(posedge clk)
    begin
        result_t   got;
        result_t   want;
        key_item_t ev;
        key_fire <= key_ch.valid && key_ch.ready;
        if (rst_n && verdict_ch.valid && verdict_ch.ready)
        begin
            got = {verdict_ch.consume, verdict_ch.toggle, verdict_ch.foreign_press,
                   verdict_ch.binding_valid};
            if (due_verdicts.size() == 0)
            begin
                $error("result word with no event pending: %b", got);
                mismatches++;
            end
            else
            begin
                want = due_verdicts.pop_front();
                settled_events++;
                for (int i = 0; i < 4; i++)
                begin
                    if (got[3-i] !== want[3-i])
                    begin
                        $error("%s: expected %0b, got %0b", verdict_fields[i], want[3-i],
                               got[3-i]);
                        mismatches++;
                    end
                end
            end
        end
        if (rst_n && key_ch.valid && key_ch.ready)
        begin
            ev = {key_ch.key_code, key_ch.event_modifier_bits, key_ch.right_alt_flag,
                  key_ch.key_down, key_ch.injected_flag, key_ch.track_external};
            due_verdicts.push_back(judge_key_event(ev));
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (key_ch.valid && key_ch.ready) || (verdict_ch.valid && verdict_ch.ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("[hotkey_press_matcher_core] ERROR");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        int p;
        int k;
        clk = 1'b0;
        rst_n = 1'b0;
        cfg_write = 1'b0;
        cfg_index = CFG_BINDING_KEY;
        cfg_data = '0;
        key_ch.valid = 1'b0;
        key_ch.key_code = '0;
        key_ch.event_modifier_bits = '0;
        key_ch.right_alt_flag = 1'b0;
        key_ch.key_down = 1'b0;
        key_ch.injected_flag = 1'b0;
        key_ch.track_external = 1'b0;
        verdict_ch.ready = 1'b0;
        key_fire = 1'b0;
        send_idle_pct = 0;
        stall_pct = 0;
        hold_requests = 0;
        holds_served = 0;
        hold_left = 0;
        quiet_cycles = 0;
        queued_events = 0;
        settled_events = 0;
        mismatches = 0;
        for (k = 0; k < TABLE_DEPTH; k++)
            mod_table[k] = 4'h0;
        seeded_mods = 4'h0;
        hotkey_held = 1'b0;
        bound_key = 8'h00;
        bound_mods = 4'h0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: ctrl+A with control seeded as held at startup
        program_binding(8'h41, MOD_CONTROL, MOD_CONTROL);
        add_key(8'h41, 4'h0, 1'b0, 1'b1, 1'b0, 1'b1);  // seeded control matches
        add_key(8'h41, 4'h0, 1'b0, 1'b1, 1'b0, 1'b1);  // repeat while held
        add_key(8'h41, 4'h0, 1'b0, 1'b0, 1'b0, 1'b1);  // release clears held
        add_key(8'hA3, MOD_CONTROL, 1'b0, 1'b1, 1'b0, 1'b1);  // supersedes the snapshot
        add_key(8'hA3, MOD_CONTROL, 1'b0, 1'b0, 1'b0, 1'b1);
        add_key(8'h41, 4'h0, 1'b0, 1'b1, 1'b0, 1'b1);  // no modifiers left: foreign press
        add_key(8'h41, 4'h0, 1'b0, 1'b1, 1'b1, 1'b1);  // injected, ignored
        add_key(8'hA0, 4'h1, 1'b0, 1'b1, 1'b0, 1'b1);  // shift is not configured
        add_key(8'hA2, MOD_CONTROL, 1'b0, 1'b1, 1'b0, 1'b1);
        add_key(8'h41, 4'h0, 1'b0, 1'b1, 1'b0, 1'b0);  // shift+ctrl does not match
        add_key(8'hA0, 4'h1, 1'b0, 1'b0, 1'b0, 1'b0);
        add_key(8'h41, 4'h0, 1'b0, 1'b1, 1'b0, 1'b0);
        add_key(8'h41, 4'h0, 1'b0, 1'b0, 1'b1, 1'b0);  // injected release keeps held
        add_key(8'h41, 4'h0, 1'b0, 1'b0, 1'b0, 1'b0);
        add_key(8'hFF, 4'hF, 1'b1, 1'b1, 1'b0, 1'b1);
        add_key(8'h00, 4'h0, 1'b0, 1'b0, 1'b0, 1'b1);
        add_key(8'hFF, 4'hF, 1'b1, 1'b0, 1'b0, 1'b0);
        add_key(8'hA2, MOD_CONTROL, 1'b0, 1'b0, 1'b0, 1'b0);
        add_key(8'h41, 4'h0, 1'b1, 1'b1, 1'b0, 1'b1);
        add_key(8'h41, 4'h0, 1'b0, 1'b0, 1'b0, 1'b1);
        wait_settled();

        for (p = 0; p < PHASES; p++)
        begin
            // let go of anything still recorded as held
            for (k = 0; k < TABLE_DEPTH; k++)
                if (mod_table[k] != 4'h0)
                    add_key(8'(k), mod_table[k], k == VK_RIGHT_ALT, 1'b0, 1'b0, 1'b0);
            wait_settled();
            program_binding(phase_key[p], phase_mods[p], phase_boot[p]);
            case (p % 4)
                0:       begin send_idle_pct = 0;  stall_pct = 0;  end
                1:       begin send_idle_pct = 85; stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  stall_pct = 85; end
                default: begin send_idle_pct = 28; stall_pct = 28; end
            endcase
            k = queued_events + PHASE_EVENTS;
            while (queued_events < k)
            begin
                if ($urandom_range(3) == 0)
                    add_noise();
                else
                    add_chord();
            end
            // receiver blocked while words keep coming: input must back up
            if (p == 0)
                hold_requests++;
            wait_settled();
        end

        if (mismatches == 0)
            $display("[hotkey_press_matcher_core] OK");
        else
            $display("[hotkey_press_matcher_core] ERROR");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/hpm_pkg.sv
rtl/hpm_if.sv
rtl/hpm_ram.sv
rtl/hpm_ctrl.sv
rtl/hpm_datapath.sv
rtl/hotkey_press_matcher_core.sv
rtl/hpm_checker.sv
tb/testbench.sv
